>>> hdl/cbd_pkg.sv
// Shared types, constants and helpers for the chunked body deframer.
`default_nettype none
package cbd_pkg;

	localparam int HEADER_MAX_CHARS_DEF = 16;
	localparam int SIZE_BITS_DEF        = 31;
	localparam int CHUNK_SIZE_W         = 31;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam logic [1:0] ROLE_SIZE  = 2'd0;
	localparam logic [1:0] ROLE_BODY  = 2'd1;
	localparam logic [1:0] ROLE_TAIL  = 2'd2;
	localparam logic [1:0] ROLE_PASS  = 2'd3;

	typedef struct packed {
		logic [7:0]              out_byte;
		logic                    data_valid;
		logic [1:0]              byte_role;
		logic                    chunk_start;
		logic [CHUNK_SIZE_W-1:0] chunk_size;
		logic                    chunk_last;
		logic                    body_end;
		logic                    header_error;
		logic                    trailer_error;
	} result_t;

	// {is_hex, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hdl/cbd_parser.sv
// Chunk framing state and per-byte decode of the chunked body deframer.
`default_nettype none
module cbd_parser #(
	parameter int HEADER_MAX_CHARS = 16,
	parameter int SIZE_BITS        = 31
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           enable,
	input  wire logic           step,
	input  wire logic [7:0]     in_byte,
	output cbd_pkg::result_t    res
);
	import cbd_pkg::*;

	localparam int HW = $clog2(HEADER_MAX_CHARS);
	localparam logic [1:0] PH_SIZE = 2'd0;
	localparam logic [1:0] PH_DATA = 2'd1;
	localparam logic [1:0] PH_TAIL = 2'd2;

	logic [1:0]           phase_q, phase_d;
	logic [SIZE_BITS:0]   acc_q, acc_d;
	logic [SIZE_BITS-1:0] remain_q, remain_d;
	logic [HW-1:0]        hcount_q, hcount_d;
	logic                 saw_cr_q, saw_cr_d;
	logic                 digits_done_q, digits_done_d;
	logic                 final_q, final_d;

	logic [4:0]           hex;
	logic [SIZE_BITS-1:0] size_val;
	logic                 is_cr, is_lf;

	assign hex      = hex_decode(in_byte);
	assign is_cr    = (in_byte == CH_CR);
	assign is_lf    = (in_byte == CH_LF);
	assign size_val = acc_q[SIZE_BITS] ? '0 : acc_q[SIZE_BITS-1:0];

	always_comb begin
		phase_d       = phase_q;
		acc_d         = acc_q;
		remain_d      = remain_q;
		hcount_d      = hcount_q;
		saw_cr_d      = saw_cr_q;
		digits_done_d = digits_done_q;
		final_d       = final_q;
		res           = '0;

		if (!enable) begin
			res.out_byte   = in_byte;
			res.data_valid = 1'b1;
			res.byte_role  = ROLE_PASS;
		end else if (phase_q == PH_DATA) begin
			res.out_byte   = in_byte;
			res.data_valid = 1'b1;
			res.byte_role  = ROLE_BODY;
			if (remain_q <= SIZE_BITS'(1)) begin
				remain_d       = '0;
				res.chunk_last = 1'b1;
				phase_d        = PH_TAIL;
				hcount_d       = '0;
				saw_cr_d       = 1'b0;
			end else begin
				remain_d = remain_q - SIZE_BITS'(1);
			end
		end else if (phase_q == PH_TAIL) begin
			res.byte_role = ROLE_TAIL;
			if (hcount_q == '0) begin
				saw_cr_d = is_cr;
				hcount_d = HW'(1);
			end else begin
				res.trailer_error = !(saw_cr_q && is_lf);
				res.body_end      = final_q;
				final_d           = 1'b0;
				phase_d           = PH_SIZE;
				acc_d             = '0;
				hcount_d          = '0;
				saw_cr_d          = 1'b0;
				digits_done_d     = 1'b0;
			end
		end else begin
			phase_d       = PH_SIZE;
			res.byte_role = ROLE_SIZE;
			if (saw_cr_q && is_lf) begin
				res.chunk_start = 1'b1;
				res.chunk_size  = CHUNK_SIZE_W'(size_val);
				acc_d           = '0;
				hcount_d        = '0;
				saw_cr_d        = 1'b0;
				digits_done_d   = 1'b0;
				if (size_val == '0) begin
					final_d = 1'b1;
					phase_d = PH_TAIL;
				end else begin
					remain_d = size_val;
					phase_d  = PH_DATA;
				end
			end else if (hcount_q >= HW'(HEADER_MAX_CHARS - 1)) begin
				res.header_error = 1'b1;
				acc_d            = '0;
				hcount_d         = '0;
				saw_cr_d         = 1'b0;
				digits_done_d    = 1'b0;
			end else begin
				hcount_d = hcount_q + HW'(1);
				saw_cr_d = is_cr;
				if (!digits_done_q) begin
					if (!hex[4]) begin
						digits_done_d = 1'b1;
					end else if (acc_q[SIZE_BITS:SIZE_BITS-4] != '0) begin
						acc_d = {1'b1, {SIZE_BITS{1'b0}}};
					end else begin
						acc_d = {1'b0, acc_q[SIZE_BITS-5:0], hex[3:0]};
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SIZE;
			acc_q         <= '0;
			remain_q      <= '0;
			hcount_q      <= '0;
			saw_cr_q      <= 1'b0;
			digits_done_q <= 1'b0;
			final_q       <= 1'b0;
		end else if (step) begin
			phase_q       <= phase_d;
			acc_q         <= acc_d;
			remain_q      <= remain_d;
			hcount_q      <= hcount_d;
			saw_cr_q      <= saw_cr_d;
			digits_done_q <= digits_done_d;
			final_q       <= final_d;
		end
	end

endmodule
`default_nettype wire

>>> hdl/chunked_body_deframer.sv
// Top level of the chunked body deframer: input stage, decoder, result register.
// Usage:
//   s_axis carries one received byte per transaction (tdata[7:0]).
//   m_axis carries exactly one result per accepted byte, in order.
//   cfg_valid/cfg_data writes chunked_enable (1 decodes chunked framing,
//   0 forwards every byte unchanged); cfg_ready is always high. Write it
//   only while no byte is in flight.
// Timing:
//   An accepted byte is held in the input stage and decoded; its result
//   is then registered for m_axis. One byte per cycle is sustained while
//   m_axis_tready is high; the per-byte state update is decode-stage logic.
// Reset:
//   arst_n clears the decoder to the size line phase, empties both stages
//   and sets chunked_enable.
// Stall:
//   While m_axis_tready is low the result holds; s_axis_tready drops once
//   both stages are full and m_axis_tready is low.
`default_nettype none
module chunked_body_deframer #(
	parameter int HEADER_MAX_CHARS = cbd_pkg::HEADER_MAX_CHARS_DEF,
	parameter int SIZE_BITS        = cbd_pkg::SIZE_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic        cfg_data,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // in_byte
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [39:0] m_axis_tdata,   // out_byte, chunk_size, zero pad
	output      logic [7:0]  m_axis_tuser,   // data_valid, byte_role, chunk_start,
	                                         // body_end, header_error,
	                                         // trailer_error, zero pad
	output      logic        m_axis_tlast    // chunk_last
);
	import cbd_pkg::*;

	logic       enable_q;
	logic [7:0] byte_s1;
	logic       valid_s1;
	result_t    res;
	result_t    res_s2;
	logic       valid_s2;
	logic       adv_s2, adv_s1;

	assign cfg_ready     = 1'b1;
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_valid) begin
			enable_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	cbd_parser #(
		.HEADER_MAX_CHARS (HEADER_MAX_CHARS),
		.SIZE_BITS        (SIZE_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.enable  (enable_q),
		.step    (adv_s1),
		.in_byte (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, res_s2.chunk_size, res_s2.out_byte};
	assign m_axis_tuser  = {1'b0, res_s2.trailer_error, res_s2.header_error,
		res_s2.body_end, res_s2.chunk_start, res_s2.byte_role, res_s2.data_valid};
	assign m_axis_tlast  = res_s2.chunk_last;

endmodule
`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for the chunked body deframer: random and directed byte streams.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cbd_pkg::*;

	typedef enum logic [1:0] {PH_LINE, PH_BODY, PH_TRAILER} deframe_phase_e;

	localparam logic [35:0] SIZE_LIMIT = (36'd1 << SIZE_BITS_DEF) - 36'd1;

	class chunk_decode_tracker;
		bit             chunked_en;
		deframe_phase_e phase;
		logic [31:0]    size_acc;
		logic [30:0]    remaining;
		logic [4:0]     hdr_count;
		bit             saw_cr;
		bit             digits_done;
		bit             final_chunk;
		result_t        awaited_results[$];

		function new();
			chunked_en  = 1'b1;
			phase       = PH_LINE;
			remaining   = '0;
			final_chunk = 1'b0;
			clear_line();
		endfunction

		function void clear_line();
			size_acc    = '0;
			hdr_count   = '0;
			saw_cr      = 1'b0;
			digits_done = 1'b0;
		endfunction

		function void take_byte(logic [7:0] b);
			result_t     r;
			logic [35:0] nv;
			logic [35:0] sz;
			int          digit;
			r = '0;
			if (!chunked_en) begin
				r.out_byte   = b;
				r.data_valid = 1'b1;
				r.byte_role  = ROLE_PASS;
			end else begin
				case (phase)
				PH_BODY: begin
					r.out_byte   = b;
					r.data_valid = 1'b1;
					r.byte_role  = ROLE_BODY;
					if (remaining <= 1) begin
						remaining    = '0;
						r.chunk_last = 1'b1;
						phase        = PH_TRAILER;
						hdr_count    = '0;
						saw_cr       = 1'b0;
					end else begin
						remaining = remaining - 1'b1;
					end
				end
				PH_TRAILER: begin
					r.byte_role = ROLE_TAIL;
					if (hdr_count == 0) begin
						saw_cr    = (b == CH_CR);
						hdr_count = 5'd1;
					end else begin
						r.trailer_error = !(saw_cr && b == CH_LF);
						r.body_end      = final_chunk;
						final_chunk     = 1'b0;
						phase           = PH_LINE;
						clear_line();
					end
				end
				default: begin
					phase       = PH_LINE;
					r.byte_role = ROLE_SIZE;
					if (saw_cr && b == CH_LF) begin
						sz            = ({4'b0, size_acc} > SIZE_LIMIT) ? 36'd0 : {4'b0, size_acc};
						r.chunk_start = 1'b1;
						r.chunk_size  = sz[30:0];
						clear_line();
						if (sz == 0) begin
							final_chunk = 1'b1;
							phase       = PH_TRAILER;
						end else begin
							remaining = sz[30:0];
							phase     = PH_BODY;
						end
					end else if (hdr_count >= HEADER_MAX_CHARS_DEF - 1) begin
						r.header_error = 1'b1;
						clear_line();
					end else begin
						hdr_count = hdr_count + 1'b1;
						saw_cr    = (b == CH_CR);
						if (!digits_done) begin
							if (b >= "0" && b <= "9")
								digit = b - "0";
							else if (b >= "a" && b <= "f")
								digit = b - "a" + 10;
							else if (b >= "A" && b <= "F")
								digit = b - "A" + 10;
							else
								digit = -1;
							if (digit < 0) begin
								digits_done = 1'b1;
							end else begin
								nv = ({4'b0, size_acc} << 4) + 36'(digit);
								if (nv > SIZE_LIMIT)
									nv = SIZE_LIMIT + 36'd1;
								size_acc = nv[31:0];
							end
						end
					end
				end
				endcase
			end
			awaited_results.push_back(r);
		endfunction

		// pops the oldest expectation; empty string when every field agrees
		function string match_result(result_t got);
			result_t want;
			string   diff;
			want = awaited_results.pop_front();
			diff = "";
			if (got.out_byte !== want.out_byte)
				diff = {diff, $sformatf(" out_byte %h/%h", got.out_byte, want.out_byte)};
			if (got.data_valid !== want.data_valid)
				diff = {diff, $sformatf(" data_valid %b/%b", got.data_valid, want.data_valid)};
			if (got.byte_role !== want.byte_role)
				diff = {diff, $sformatf(" byte_role %0d/%0d", got.byte_role, want.byte_role)};
			if (got.chunk_start !== want.chunk_start)
				diff = {diff, $sformatf(" chunk_start %b/%b", got.chunk_start, want.chunk_start)};
			if (got.chunk_size !== want.chunk_size)
				diff = {diff, $sformatf(" chunk_size %h/%h", got.chunk_size, want.chunk_size)};
			if (got.chunk_last !== want.chunk_last)
				diff = {diff, $sformatf(" chunk_last %b/%b", got.chunk_last, want.chunk_last)};
			if (got.body_end !== want.body_end)
				diff = {diff, $sformatf(" body_end %b/%b", got.body_end, want.body_end)};
			if (got.header_error !== want.header_error)
				diff = {diff, $sformatf(" header_error %b/%b", got.header_error,
					want.header_error)};
			if (got.trailer_error !== want.trailer_error)
				diff = {diff, $sformatf(" trailer_error %b/%b", got.trailer_error,
					want.trailer_error)};
			return diff;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_data = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata = '0;
	logic        m_tready = 1'b0;
	logic        cfg_ready;
	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic [39:0] m_axis_tdata;
	logic [7:0]  m_axis_tuser;
	logic        m_axis_tlast;

	chunk_decode_tracker tracker;
	int unsigned         mismatches = 0;
	int unsigned         items_sent = 0;
	bit                  quiet = 1'b0;
	bit                  hold_req = 1'b0;

	chunked_body_deframer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(string what);
		$display("%0t ns mismatch:%s", $time, what);
		mismatches++;
	endtask

	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_byte(b);
		items_sent++;
	endtask

	function automatic logic [7:0] non_cr();
		logic [7:0] b;
		b = 8'($urandom_range(0, 254));
		if (b >= CH_CR)
			b = b + 8'd1;
		return b;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] v);
		logic [7:0] c;
		c = (v < 4'd10) ? 8'h30 + v : 8'h61 + v - 8'd10;
		if (v >= 4'd10 && $urandom_range(0, 1))
			c = c - 8'h20;
		return c;
	endfunction

	task automatic send_size_line(logic [39:0] sz, int lead_zeros, int ext_len);
		int nd;
		nd = 1;
		while (nd < 10 && (sz >> (4 * nd)) != 0)
			nd++;
		repeat (lead_zeros) send_byte("0");
		for (int i = nd - 1; i >= 0; i--)
			send_byte(hex_char(sz[4*i +: 4]));
		if (ext_len > 0) begin
			send_byte(";");
			repeat (ext_len - 1) send_byte(8'($urandom_range(0, 255)));
		end
		send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	task automatic send_trailer();
		case ($urandom_range(0, 9))
		0: begin
			send_byte(non_cr());
			send_byte(8'($urandom_range(0, 255)));
		end
		1: begin
			send_byte(CH_CR);
			send_byte(8'($urandom_range(0, 255)));
		end
		default: begin
			send_byte(CH_CR);
			send_byte(CH_LF);
		end
		endcase
	endtask

	// steer the decoder back to the start of a size line without large sizes
	task automatic sync_to_line();
		while (!(tracker.phase == PH_LINE && tracker.hdr_count == 0)) begin
			if (tracker.phase == PH_BODY)
				send_byte(8'($urandom_range(0, 255)));
			else if (tracker.phase == PH_TRAILER)
				send_byte(tracker.hdr_count == 0 ? CH_CR : CH_LF);
			else if (tracker.saw_cr)
				send_byte(CH_LF);
			else if (tracker.size_acc <= 64)
				send_byte(CH_CR);
			else
				send_byte("z");
		end
	endtask

	task automatic send_chunk_sequence();
		int          kind;
		int unsigned sz;
		sync_to_line();
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			sz = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			send_size_line(40'(sz), $urandom_range(0, 2),
				($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
			repeat (sz) send_byte(8'($urandom_range(0, 255)));
			send_trailer();
		end else if (kind < 72) begin
			send_size_line(40'd0, $urandom_range(0, 2),
				($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
			send_trailer();
		end else if (kind < 82) begin
			repeat ($urandom_range(15, 20)) send_byte(non_cr());
		end else if (kind < 90) begin
			send_size_line({8'($urandom_range(0, 255)), 32'($urandom)} | 40'h80000000,
				0, 0);
			send_trailer();
		end else begin
			repeat ($urandom_range(1, 6)) send_byte(non_cr());
		end
	endtask

	task automatic wait_drain();
		while (tracker.awaited_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(bit enable);
		cfg_valid <= 1'b1;
		cfg_data  <= enable;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		tracker.chunked_en = enable;
	endtask

	task automatic check_result();
		result_t got;
		string   diff;
		got               = '0;
		got.out_byte      = m_axis_tdata[7:0];
		got.chunk_size    = m_axis_tdata[38:8];
		got.data_valid    = m_axis_tuser[0];
		got.byte_role     = m_axis_tuser[2:1];
		got.chunk_start   = m_axis_tuser[3];
		got.body_end      = m_axis_tuser[4];
		got.header_error  = m_axis_tuser[5];
		got.trailer_error = m_axis_tuser[6];
		got.chunk_last    = m_axis_tlast;
		if (tracker.awaited_results.size() == 0) begin
			report_mismatch(" result with nothing awaited");
		end else begin
			diff = tracker.match_result(got);
			if (diff != "")
				report_mismatch(diff);
		end
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				stall = quiet ? 0 : $urandom_range(0, 18);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			check_result();
		end
	end

	initial begin
		logic [7:0] directed[] = '{
			"2", ";", CH_LF, CH_CR, CH_LF,            // text after digits, bare LF
			8'h00, 8'hFF,                             // body extremes
			"X", CH_LF,                               // bad trailer
			"8", "0", "0", "0", "0", "0", "0", "0",   // oversized size
			CH_CR, CH_LF,
			CH_CR, CH_CR                              // bad closing pair
		};
		int unsigned phase_end;
		bit          enable;
		tracker = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_byte(directed[i]);
		for (int p = 0; p < 8; p++) begin
			s_tvalid <= 1'b0;
			wait_drain();
			enable = (p % 3 != 1);
			write_mode(enable);
			quiet = (p == 3 || p == 6);
			if (p == 2)
				hold_req = 1'b1;
			if (enable) begin
				phase_end = items_sent + 75;
				while (items_sent < phase_end)
					send_chunk_sequence();
			end else begin
				repeat (40) send_byte(8'($urandom_range(0, 255)));
			end
		end
		s_tvalid <= 1'b0;
		wait_drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule
`default_nettype wire
